### design/fpdf_pkg.sv
// ----------------------------------------------------------------------------
// fpdf_pkg: shared definitions for the fixed-point decimal formatter
// Holds the field widths, character codes, register indexes and the word
// type that carries converted digits from the converter to the emitter.
// ----------------------------------------------------------------------------
package fpdf_pkg;

    localparam int BIN_W        = 64;
    localparam int MAX_DIGITS   = 19;
    localparam int MAX_FRACTION = 40;
    localparam int BCD_W        = MAX_DIGITS * 4;
    localparam int COUNT_W      = 5;
    localparam int FRAC_W       = 6;
    localparam int CHAR_W       = 8;
    localparam int BITCNT_W     = $clog2(BIN_W);
    localparam int CFG_IDX_W    = 2;

    localparam logic [CHAR_W-1:0] DIGIT_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2d;

    localparam logic [CHAR_W-1:0] SEP_RESET   = 8'd44;
    localparam logic [CHAR_W-1:0] POINT_RESET = 8'd46;
    localparam logic [FRAC_W-1:0] FRAC_RESET  = 6'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_SEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRACTION  = 2'd2;

    // Converted number handed from the converter to the emitter.
    // Digits are aligned to the top of the vector, most significant first.
    typedef struct packed {
        logic               negative;
        logic [COUNT_W-1:0] count;
        logic [BCD_W-1:0]   digits;
    } digit_word_t;

    // Remainder modulo three of a small count, by alternating bit weights.
    function automatic logic [1:0] mod3(input logic [COUNT_W-1:0] v);
        logic [1:0] acc;
        logic [2:0] s;
        acc = 2'd0;
        for (int i = 0; i < COUNT_W; i++) begin
            s = {1'b0, acc} + ((i % 2 == 0) ? 3'd1 : 3'd2);
            if (v[i]) begin
                acc = (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
            end
        end
        return acc;
    endfunction

endpackage

### design/fixed_point_decimal_formatter_top.sv
// ----------------------------------------------------------------------------
// fixed_point_decimal_formatter_top: signed scaled integer to decimal text
// Converts a 64-bit two's complement word to ASCII characters with sign,
// digit grouping and a decimal point, one character per output word.
// ----------------------------------------------------------------------------
// Usage:
// The s_ channel takes one signed 64-bit word per number. The m_ channel
// returns the text one character per word, with m_last_char high on the
// final character of each number. The cfg_ channel writes the group
// separator (index 0), the point character (index 1) and the number of
// fraction digits (index 2, 6 bits, saturated at 40); other indexes ignored.
// Configuration is meant to change only while no number is in flight.
// Flow: the magnitude goes through bit-serial double dabble, leading zero
// digits are stripped (up to 19), the digits are handed to the emitter and
// the first character is registered. Characters then leave at one per
// cycle, up to 43, while the receiver keeps up.
// Overlap: the converter takes the next number the cycle after the
// emitter picks up the digits, so conversion overlaps emission. With a
// receiver that keeps up, the rate of new numbers is set by the conversion
// alone; even a 43-character text is out before the next digits are ready.
// Reset clears all control state and loads the register defaults (',',
// '.', two fraction digits). A stalled receiver simply holds the output
// word; the emitter waits and the converter stalls in turn.
// ----------------------------------------------------------------------------
module fixed_point_decimal_formatter_top
    import fpdf_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [BIN_W-1:0] s_value,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [CHAR_W-1:0]       m_char_code,
    output logic                    m_last_char,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CHAR_W-1:0]       cfg_data
);

    logic [CHAR_W-1:0] group_sep_reg;
    logic [CHAR_W-1:0] point_char_reg;
    logic [FRAC_W-1:0] frac_digits_reg;

    logic        dw_valid;
    logic        dw_ready;
    digit_word_t dw_word;

    // The register file accepts a write on every cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_sep_reg   <= SEP_RESET;
            point_char_reg  <= POINT_RESET;
            frac_digits_reg <= FRAC_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_GROUP_SEP: group_sep_reg   <= cfg_data;
                CFG_POINT:     point_char_reg  <= cfg_data;
                CFG_FRACTION:  frac_digits_reg <= cfg_data[FRAC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Bit-serial conversion of the magnitude into normalized BCD digits.
    fpdf_convert u_convert (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_value  (s_value),
        .dw_valid (dw_valid),
        .dw_ready (dw_ready),
        .dw_word  (dw_word)
    );

    // Character sequencer with its own output register.
    fpdf_emit u_emit (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .dw_valid        (dw_valid),
        .dw_ready        (dw_ready),
        .dw_word         (dw_word),
        .group_separator (group_sep_reg),
        .point_char      (point_char_reg),
        .fraction_digits (frac_digits_reg),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_char_code     (m_char_code),
        .m_last_char     (m_last_char)
    );

endmodule

### design/fpdf_convert.sv
// ----------------------------------------------------------------------------
// fpdf_convert: bit-serial binary to decimal converter
// Takes the magnitude one bit per cycle into a BCD shift register, then
// strips leading zero digits one per cycle to find the digit count.
// ----------------------------------------------------------------------------
module fpdf_convert
    import fpdf_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [BIN_W-1:0] s_value,
    output logic                    dw_valid,
    input  logic                    dw_ready,
    output digit_word_t             dw_word
);

    typedef enum logic [1:0] {C_IDLE, C_CONV, C_NORM, C_DONE} conv_state_t;

    conv_state_t         state_reg, state_next;
    logic [BIN_W-1:0]    bin_reg, bin_next;
    logic [BCD_W-1:0]    bcd_reg, bcd_next;
    logic [BCD_W-1:0]    bcd_adj;
    logic [BITCNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                neg_reg, neg_next;

    // Each digit of five or more gets three added before the shift.
    always_comb begin
        for (int d = 0; d < MAX_DIGITS; d++) begin
            bcd_adj[d*4 +: 4] = (bcd_reg[d*4 +: 4] >= 4'd5) ?
                                4'(bcd_reg[d*4 +: 4] + 4'd3) : bcd_reg[d*4 +: 4];
        end
    end

    always_comb begin
        state_next   = state_reg;
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        count_next   = count_reg;
        neg_next     = neg_reg;
        unique case (state_reg)
            C_IDLE: begin
                if (s_valid) begin
                    neg_next     = s_value[BIN_W-1];
                    bin_next     = s_value[BIN_W-1] ? (~s_value + 1'b1) : s_value;
                    bcd_next     = '0;
                    bit_cnt_next = '0;
                    state_next   = C_CONV;
                end
            end
            C_CONV: begin
                bcd_next     = {bcd_adj[BCD_W-2:0], bin_reg[BIN_W-1]};
                bin_next     = {bin_reg[BIN_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == BITCNT_W'(BIN_W - 1)) begin
                    count_next = COUNT_W'(MAX_DIGITS);
                    state_next = C_NORM;
                end
            end
            C_NORM: begin
                if (count_reg != '0 && bcd_reg[BCD_W-1 -: 4] == 4'd0) begin
                    bcd_next   = {bcd_reg[BCD_W-5:0], 4'd0};
                    count_next = count_reg - 1'b1;
                end else begin
                    state_next = C_DONE;
                end
            end
            C_DONE: begin
                if (dw_ready) begin
                    state_next = C_IDLE;
                end
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= C_IDLE;
            bit_cnt_reg <= '0;
            count_reg   <= '0;
            neg_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            count_reg   <= count_next;
            neg_reg     <= neg_next;
        end
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign s_ready           = (state_reg == C_IDLE);
    assign dw_valid          = (state_reg == C_DONE);
    assign dw_word.negative  = neg_reg;
    assign dw_word.count     = count_reg;
    assign dw_word.digits    = bcd_reg;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == C_CONV && bit_cnt_reg == '0))
        else $error("accepted word did not start conversion");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == C_DONE) |-> (count_reg <= COUNT_W'(MAX_DIGITS)))
        else $error("digit count out of range");
    a_top_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == C_DONE && count_reg != '0) |-> (bcd_reg[BCD_W-1 -: 4] != 4'd0))
        else $error("leading digit of a nonzero count is zero");
`endif

endmodule

### design/fpdf_emit.sv
// ----------------------------------------------------------------------------
// fpdf_emit: character sequencer, one character per cycle unless stalled
// Walks the sign, integer digits with group separators (or a zero), point,
// padding zeros and fraction digits into an output register.
// ----------------------------------------------------------------------------
module fpdf_emit
    import fpdf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              dw_valid,
    output logic              dw_ready,
    input  digit_word_t       dw_word,
    input  logic [CHAR_W-1:0] group_separator,
    input  logic [CHAR_W-1:0] point_char,
    input  logic [FRAC_W-1:0] fraction_digits,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CHAR_W-1:0] m_char_code,
    output logic              m_last_char
);

    typedef enum logic [2:0] {
        E_IDLE, E_SIGN, E_INT, E_SEP, E_ZERO, E_POINT, E_PAD, E_FRAC
    } emit_state_t;

    emit_state_t        state_reg, state_next;
    logic [BCD_W-1:0]   digits_reg, digits_next;
    logic [COUNT_W-1:0] int_rem_reg, int_rem_next;
    logic [1:0]         grp_reg, grp_next;
    logic [FRAC_W-1:0]  pad_rem_reg, pad_rem_next;
    logic [FRAC_W-1:0]  frac_rem_reg, frac_rem_next;
    logic               m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic               last_reg, last_next;

    logic               advance;
    logic [FRAC_W-1:0]  p_sat;
    logic [FRAC_W-1:0]  n_ext;
    logic [COUNT_W-1:0] intlen;
    logic [CHAR_W-1:0]  top_char;

    assign p_sat    = (fraction_digits > FRAC_W'(MAX_FRACTION)) ?
                      FRAC_W'(MAX_FRACTION) : fraction_digits;
    assign n_ext    = {{(FRAC_W-COUNT_W){1'b0}}, dw_word.count};
    assign intlen   = COUNT_W'(n_ext - p_sat);
    assign top_char = DIGIT_ZERO + {4'd0, digits_reg[BCD_W-1 -: 4]};
    assign advance  = (state_reg != E_IDLE) && (!m_valid_reg || m_ready);
    assign dw_ready = (state_reg == E_IDLE);

    always_comb begin
        state_next    = state_reg;
        digits_next   = digits_reg;
        int_rem_next  = int_rem_reg;
        grp_next      = grp_reg;
        pad_rem_next  = pad_rem_reg;
        frac_rem_next = frac_rem_reg;
        m_valid_next  = m_valid_reg;
        char_next     = char_reg;
        last_next     = last_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (state_reg == E_IDLE) begin
            if (dw_valid) begin
                digits_next = dw_word.digits;
                if (n_ext > p_sat) begin
                    int_rem_next  = intlen;
                    grp_next      = mod3(intlen);
                    pad_rem_next  = '0;
                    frac_rem_next = p_sat;
                    state_next    = dw_word.negative ? E_SIGN : E_INT;
                end else begin
                    int_rem_next  = '0;
                    grp_next      = 2'd0;
                    pad_rem_next  = p_sat - n_ext;
                    frac_rem_next = n_ext;
                    state_next    = dw_word.negative ? E_SIGN : E_ZERO;
                end
            end
        end else if (advance) begin
            m_valid_next = 1'b1;
            last_next    = 1'b0;
            unique case (state_reg)
                E_SIGN: begin
                    char_next  = MINUS_CHAR;
                    state_next = (int_rem_reg != '0) ? E_INT : E_ZERO;
                end
                E_ZERO: begin
                    char_next  = DIGIT_ZERO;
                    state_next = E_POINT;
                end
                E_INT: begin
                    char_next    = top_char;
                    digits_next  = {digits_reg[BCD_W-5:0], 4'd0};
                    int_rem_next = int_rem_reg - 1'b1;
                    grp_next     = (grp_reg == 2'd0) ? 2'd2 : grp_reg - 1'b1;
                    if (int_rem_reg == COUNT_W'(1)) begin
                        state_next = E_POINT;
                    end else if (grp_reg == 2'd1) begin
                        state_next = E_SEP;
                    end
                end
                E_SEP: begin
                    char_next  = group_separator;
                    state_next = E_INT;
                end
                E_POINT: begin
                    char_next = point_char;
                    if (pad_rem_reg != '0) begin
                        state_next = E_PAD;
                    end else if (frac_rem_reg != '0) begin
                        state_next = E_FRAC;
                    end else begin
                        last_next  = 1'b1;
                        state_next = E_IDLE;
                    end
                end
                E_PAD: begin
                    char_next    = DIGIT_ZERO;
                    pad_rem_next = pad_rem_reg - 1'b1;
                    if (pad_rem_reg == FRAC_W'(1)) begin
                        if (frac_rem_reg != '0) begin
                            state_next = E_FRAC;
                        end else begin
                            last_next  = 1'b1;
                            state_next = E_IDLE;
                        end
                    end
                end
                E_FRAC: begin
                    char_next     = top_char;
                    digits_next   = {digits_reg[BCD_W-5:0], 4'd0};
                    frac_rem_next = frac_rem_reg - 1'b1;
                    if (frac_rem_reg == FRAC_W'(1)) begin
                        last_next  = 1'b1;
                        state_next = E_IDLE;
                    end
                end
                default: state_next = E_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= E_IDLE;
            int_rem_reg  <= '0;
            grp_reg      <= '0;
            pad_rem_reg  <= '0;
            frac_rem_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            int_rem_reg  <= int_rem_next;
            grp_reg      <= grp_next;
            pad_rem_reg  <= pad_rem_next;
            frac_rem_reg <= frac_rem_next;
            m_valid_reg  <= m_valid_next;
        end
        digits_reg <= digits_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_char_code = char_reg;
    assign m_last_char = last_reg;

`ifndef SYNTHESIS
    a_int_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == E_INT) |-> (int_rem_reg != '0))
        else $error("integer phase with no digits left");
    a_frac_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == E_FRAC) |-> (frac_rem_reg != '0))
        else $error("fraction phase with no digits left");
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && last_next) |=> (state_reg == E_IDLE && m_valid_reg && last_reg))
        else $error("final character did not end the number");
`endif

endmodule
